// ===== design/ffha_pkg.sv =====
// ffha_pkg: shared types and constants for the first-fit heap allocator
// heap geometry, header entry layout, opcode and status codes
// no dependencies
package ffha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 24;

    localparam int ADDR_W = 48;
    localparam int REQ_W  = 17;
    localparam int USED_W = 17;
    localparam int STAT_W = 2;

    // headers sit on 8-byte words; offsets and sizes are kept in words
    localparam int OFF_W      = $clog2(HEAP_BYTES);
    localparam int IDX_W      = OFF_W - 3;
    localparam int DEPTH      = HEAP_BYTES / 8;
    localparam int WLEN_W     = IDX_W + 1;
    localparam int SIZE_W     = IDX_W;
    localparam int NEED_W     = REQ_W - 2;
    localparam int HDR_WORDS  = HEADER_BYTES / 8;
    localparam int SPLIT_MIN  = (2 * HEADER_BYTES + 8) / 8;
    localparam int SIZE0      = (HEAP_BYTES - HEADER_BYTES) / 8;

    localparam int S_TDATA_W = ((REQ_W + ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ADDR_W + STAT_W + USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size_w;
    } hdr_t;

    localparam hdr_t HDR_RESET = '{free: 1'b1, size_w: SIZE_W'(SIZE0)};

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FAIL = 2'd1,
        STAT_BAD  = 2'd2
    } stat_t;

endpackage

// ===== design/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: first-fit allocator with block headers in one on-chip memory
// walks headers one per cycle, splits on allocate, merges on release
// depends on ffha_pkg
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   tuser: opcode; tdata: request_bytes, release_address
//  m_        out  m_tvalid/m_tready   tdata: payload_address, status, used_bytes
//  cfg_      in   cfg_valid/cfg_ready cfg_data: heap_base
//
// one request at a time: a start step, the header walk, a tail write on a split,
// then the output register load; the header read feeds the next read
// address, so the walk runs at one header per cycle through the memory port.
// reset leaves one free block spanning the heap; no clearing pass is needed.
// a new request is taken once the previous result sits in the output register.
module first_fit_heap_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,   // [0] opcode
    // [16:0] request_bytes, [64:17] release_address, rest zero
    input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [47:0] payload_address, [49:48] status, [66:50] used_bytes, rest zero
    output logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffha_pkg::ADDR_W-1:0]     cfg_data
);
    import ffha_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_WALK  = 5'b00100,
        S_WR2   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // header memory
    hdr_t              mem [DEPTH];
    hdr_t              rdata_reg;
    logic              rd_zero_reg;
    logic              hdr0_written_reg;
    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    hdr_t              wr_data;

    // request and walk state
    op_t               op_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [ADDR_W-1:0] rel_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [IDX_W-1:0]  tgt_w_reg, tgt_w_next;
    logic [IDX_W-1:0]  cur_w_reg, cur_w_next;
    logic [IDX_W-1:0]  prev_w_reg, prev_w_next;
    logic [SIZE_W-1:0] prev_size_reg, prev_size_next;
    logic              prev_free_reg, prev_free_next;
    logic              found_reg, found_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0]  tail_addr_reg, tail_addr_next;
    hdr_t              tail_data_reg, tail_data_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    stat_t             res_stat_reg, res_stat_next;

    // output register
    logic              m_tvalid_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    stat_t             m_stat_reg;
    logic [USED_W-1:0] m_used_reg;

    // walk datapath
    hdr_t              hdr;
    logic [WLEN_W-1:0] next_w;
    logic              at_end;
    logic [NEED_W-1:0] size_ext, diff;
    logic              fit, split, is_tgt, newly, stop_bad, free_eff;
    logic [ADDR_W-1:0] tgt_off;
    logic              tgt_ok;
    logic [USED_W-1:0] size_bytes, need_bytes;
    logic [SIZE_W-1:0] merged;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_TDATA_W'({m_used_reg, m_stat_reg, m_addr_reg});

    // header memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg   <= mem[rd_addr];
            rd_zero_reg <= (rd_addr == '0) && !hdr0_written_reg;
        end
    end

    assign hdr      = rd_zero_reg ? HDR_RESET : rdata_reg;
    assign next_w   = WLEN_W'(cur_w_reg) + WLEN_W'(HDR_WORDS) + WLEN_W'(hdr.size_w);
    assign at_end   = next_w >= WLEN_W'(DEPTH);
    assign size_ext = NEED_W'(hdr.size_w);
    assign fit      = hdr.free && (size_ext >= need_reg);
    assign diff     = size_ext - need_reg;
    assign split    = diff > NEED_W'(SPLIT_MIN);
    assign is_tgt   = (cur_w_reg == tgt_w_reg);
    assign size_bytes = USED_W'({hdr.size_w, 3'b000});
    assign need_bytes = USED_W'({need_reg, 3'b000});
    assign merged   = SIZE_W'(WLEN_W'(prev_size_reg) + WLEN_W'(HDR_WORDS)
                              + WLEN_W'(hdr.size_w));

    // release target as a byte offset into the heap, checked for word alignment and range
    assign tgt_off = rel_reg - base_reg - ADDR_W'(HEADER_BYTES);
    assign tgt_ok  = (tgt_off[2:0] == 3'b000) && (tgt_off[ADDR_W-1:OFF_W] == '0);

    always_comb begin
        state_next     = state_reg;
        rd_en          = 1'b0;
        rd_addr        = next_w[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = cur_w_reg;
        wr_data        = hdr;
        need_next      = need_reg;
        tgt_w_next     = tgt_w_reg;
        cur_w_next     = cur_w_reg;
        prev_w_next    = prev_w_reg;
        prev_size_next = prev_size_reg;
        prev_free_next = prev_free_reg;
        found_next     = found_reg;
        used_next      = used_reg;
        tail_addr_next = tail_addr_reg;
        tail_data_next = tail_data_reg;
        res_addr_next  = res_addr_reg;
        res_stat_next  = res_stat_reg;
        newly          = 1'b0;
        stop_bad       = 1'b0;
        free_eff       = hdr.free;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                need_next      = NEED_W'((REQ_W + 1)'(req_reg) + (REQ_W + 1)'(7) >> 3);
                tgt_w_next     = tgt_off[OFF_W-1:3];
                prev_free_next = 1'b0;
                found_next     = 1'b0;
                cur_w_next     = '0;
                res_addr_next  = '0;
                rd_addr        = '0;
                if (op_reg == OP_ALLOC && req_reg == '0) begin
                    res_stat_next = STAT_FAIL;
                    state_next    = S_OUT;
                end else if (op_reg == OP_RELEASE && !tgt_ok) begin
                    res_stat_next = STAT_BAD;
                    state_next    = S_OUT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (op_reg == OP_ALLOC) begin
                    if (fit) begin
                        wr_en          = 1'b1;
                        wr_data.free   = 1'b0;
                        wr_data.size_w = split ? SIZE_W'(need_reg) : hdr.size_w;
                        used_next      = used_reg + (split ? need_bytes : size_bytes);
                        res_addr_next  = base_reg
                                         + ADDR_W'({WLEN_W'(cur_w_reg) + WLEN_W'(HDR_WORDS),
                                                    3'b000});
                        res_stat_next  = STAT_OK;
                        // free tail goes in on the next cycle
                        tail_addr_next = IDX_W'(WLEN_W'(cur_w_reg) + WLEN_W'(HDR_WORDS)
                                                + WLEN_W'(need_reg));
                        tail_data_next = '{free: 1'b1,
                                           size_w: SIZE_W'(diff - NEED_W'(HDR_WORDS))};
                        state_next     = split ? S_WR2 : S_OUT;
                    end else if (at_end) begin
                        res_addr_next = '0;
                        res_stat_next = STAT_FAIL;
                        state_next    = S_OUT;
                    end else begin
                        rd_en      = 1'b1;
                        cur_w_next = next_w[IDX_W-1:0];
                    end
                end else begin
                    if (!found_reg) begin
                        if (is_tgt) begin
                            if (hdr.free) begin
                                stop_bad = 1'b1;
                            end else begin
                                newly     = 1'b1;
                                free_eff  = 1'b1;
                                used_next = used_reg - size_bytes;
                            end
                        end else if (cur_w_reg > tgt_w_reg || at_end) begin
                            stop_bad = 1'b1;
                        end
                    end
                    if (stop_bad) begin
                        res_stat_next = STAT_BAD;
                        state_next    = S_OUT;
                    end else begin
                        if (prev_free_reg && free_eff) begin
                            // fold this block into the free block before it
                            wr_en          = 1'b1;
                            wr_addr        = prev_w_reg;
                            wr_data        = '{free: 1'b1, size_w: merged};
                            prev_size_next = merged;
                        end else begin
                            if (newly) begin
                                wr_en        = 1'b1;
                                wr_data.free = 1'b1;
                            end
                            prev_w_next    = cur_w_reg;
                            prev_size_next = hdr.size_w;
                            prev_free_next = free_eff;
                        end
                        found_next = found_reg || newly;
                        if (found_reg || at_end) begin
                            res_stat_next = STAT_OK;
                            state_next    = S_OUT;
                        end else begin
                            rd_en      = 1'b1;
                            cur_w_next = next_w[IDX_W-1:0];
                        end
                    end
                end
            end
            S_WR2: begin
                wr_en      = 1'b1;
                wr_addr    = tail_addr_reg;
                wr_data    = tail_data_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            used_reg         <= '0;
            base_reg         <= '0;
            hdr0_written_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            if (wr_en && wr_addr == '0) begin
                hdr0_written_reg <= 1'b1;
            end
            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= op_t'(s_tuser);
            req_reg <= s_tdata[REQ_W-1:0];
            rel_reg <= s_tdata[REQ_W +: ADDR_W];
        end
        need_reg      <= need_next;
        tgt_w_reg     <= tgt_w_next;
        cur_w_reg     <= cur_w_next;
        prev_w_reg    <= prev_w_next;
        prev_size_reg <= prev_size_next;
        prev_free_reg <= prev_free_next;
        found_reg     <= found_next;
        tail_addr_reg <= tail_addr_next;
        tail_data_reg <= tail_data_next;
        res_addr_reg  <= res_addr_next;
        res_stat_reg  <= res_stat_next;
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            m_addr_reg <= res_addr_reg;
            m_stat_reg <= res_stat_reg;
            m_used_reg <= used_reg;
        end
    end

    // never read and write the same header in one cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("header read and write hit the same entry");

    // blocks tile the heap, so a walk never steps past its end
    a_walk_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (next_w <= WLEN_W'(DEPTH)))
        else $error("header walk ran past the heap end");

    // the tail write only follows a walk step
    a_wr2_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR2) |-> $past(state_reg == S_WALK))
        else $error("split tail write without a walk step");

    // a result appears only when the output stage is loaded
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result valid raised outside the output state");

endmodule
